// ===== rtl/sas_pkg.sv =====
// Shared types and codes for the multi-stack block on one slot memory.
// No dependencies; used by the controller, the datapath and the top level.
package sas_pkg;

    // Default sizes
    localparam int DEF_TOTAL_SLOTS = 16;
    localparam int DEF_DATA_WIDTH  = 32;

    // Fixed field widths and limits
    localparam int MAX_STACKS = 16;
    localparam int CMD_W      = 2;
    localparam int INDEX_W    = 4;
    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 5;

    // Command codes; the fourth code is unused and gives no result
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_BAD   = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ
    } state_t;

    // One input item
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [INDEX_W-1:0] stack_index;
        logic [WORD_W-1:0]  data_value;
    } request_t;

    // One result item
    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] data_out;
        logic              last;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;       // latch the accepted item
        logic    push;       // store the word and bump the fill
        logic    read_top;   // read the newest word, set up the walk
        logic    read_next;  // read the next older word
        logic    pop;        // with read_top: drop the newest word
        logic    emit;       // load the result register
        status_t emit_status;
        logic    emit_data;  // take the word read from memory
        logic    emit_last;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             bad_index;
        logic             full;
        logic             empty;
        logic             remain_zero;
    } dp_status_t;

endpackage

// ===== rtl/sas_ctrl.sv =====
// Controller state machine of the multi-stack block.
// Depends on sas_pkg for the state, command and status types.
module sas_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  sas_pkg::dp_status_t   dp_stat,
    output sas_pkg::ctrl_cmd_t    ctrl_cmd
);
    import sas_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // Next state and datapath commands
    always_comb
    begin
        state_next           = state_reg;
        ctrl_cmd             = '0;
        ctrl_cmd.emit_status = STATUS_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl_cmd.load = 1'b1;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_IDLE;
                if (dp_stat.command inside {CMD_PUSH, CMD_POP, CMD_LIST})
                begin
                    ctrl_cmd.emit_last = 1'b1;
                    if (dp_stat.bad_index)
                    begin
                        ctrl_cmd.emit        = 1'b1;
                        ctrl_cmd.emit_status = STATUS_BAD;
                    end
                    else if (dp_stat.command == CMD_PUSH)
                    begin
                        ctrl_cmd.emit = 1'b1;
                        if (dp_stat.full)
                        begin
                            ctrl_cmd.emit_status = STATUS_FULL;
                        end
                        else
                        begin
                            ctrl_cmd.push = 1'b1;
                        end
                    end
                    else if (dp_stat.empty)
                    begin
                        ctrl_cmd.emit        = 1'b1;
                        ctrl_cmd.emit_status = STATUS_EMPTY;
                    end
                    else
                    begin
                        // Start the read; the word is emitted once it lands
                        ctrl_cmd.read_top = 1'b1;
                        ctrl_cmd.pop      = (dp_stat.command == CMD_POP);
                        state_next        = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                ctrl_cmd.emit      = 1'b1;
                ctrl_cmd.emit_data = 1'b1;
                ctrl_cmd.emit_last = dp_stat.remain_zero;
                if (dp_stat.remain_zero)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctrl_cmd.read_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sas_dp.sv =====
// Datapath of the multi-stack block: slot memory, fill counts, region maths,
// walk pointer and result register. Depends on sas_pkg.
module sas_dp #(
    parameter int TOTAL_SLOTS = sas_pkg::DEF_TOTAL_SLOTS,
    parameter int DATA_WIDTH  = sas_pkg::DEF_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [sas_pkg::COUNT_W-1:0]  cfg_data,
    input  sas_pkg::request_t            request,
    input  sas_pkg::ctrl_cmd_t           ctrl_cmd,
    output sas_pkg::dp_status_t          dp_stat,
    output sas_pkg::result_t             result,
    output logic                         result_valid
);
    import sas_pkg::*;

    localparam int CW    = $clog2(TOTAL_SLOTS + 1);
    localparam int AW    = $clog2(TOTAL_SLOTS);
    localparam int MAX_N = (MAX_STACKS < TOTAL_SLOTS) ? MAX_STACKS : TOTAL_SLOTS;

    // Region size for each stack count, worked out at elaboration
    localparam logic [CW-1:0] REGION_TBL [MAX_STACKS] = '{
        CW'(TOTAL_SLOTS / 1),  CW'(TOTAL_SLOTS / 2),  CW'(TOTAL_SLOTS / 3),
        CW'(TOTAL_SLOTS / 4),  CW'(TOTAL_SLOTS / 5),  CW'(TOTAL_SLOTS / 6),
        CW'(TOTAL_SLOTS / 7),  CW'(TOTAL_SLOTS / 8),  CW'(TOTAL_SLOTS / 9),
        CW'(TOTAL_SLOTS / 10), CW'(TOTAL_SLOTS / 11), CW'(TOTAL_SLOTS / 12),
        CW'(TOTAL_SLOTS / 13), CW'(TOTAL_SLOTS / 14), CW'(TOTAL_SLOTS / 15),
        CW'(TOTAL_SLOTS / 16)
    };

    request_t               item_reg;
    logic [COUNT_W-1:0]     stack_count_reg;
    logic [CW-1:0]          region_size_reg;
    logic [CW-1:0]          fill_count_reg [MAX_STACKS];
    logic [CW-1:0]          remain_reg;
    logic [AW-1:0]          ptr_reg;
    logic [DATA_WIDTH-1:0]  mem [TOTAL_SLOTS];
    logic [DATA_WIDTH-1:0]  rd_data_reg;
    result_t                result_reg;
    logic                   result_valid_reg;

    logic [COUNT_W-1:0]     count_clamped;
    logic [INDEX_W-1:0]     tbl_idx;
    logic [INDEX_W-1:0]     sel;
    logic [CW-1:0]          fill;
    logic [CW+INDEX_W-1:0]  base_full;
    logic [CW-1:0]          base;
    logic [CW-1:0]          capacity;
    logic                   last_stack;
    logic [CW-1:0]          top_slot;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          top_addr;
    logic [AW-1:0]          rd_addr;
    logic                   rd_en;

    // Clamp the written stack count to one up to the largest legal count
    always_comb
    begin
        if (cfg_data == '0)
        begin
            count_clamped = COUNT_W'(1);
        end
        else if (cfg_data > COUNT_W'(MAX_N))
        begin
            count_clamped = COUNT_W'(MAX_N);
        end
        else
        begin
            count_clamped = cfg_data;
        end
    end
    assign tbl_idx = INDEX_W'(count_clamped - COUNT_W'(1));

    // Region of the addressed stack
    assign sel        = item_reg.stack_index;
    assign fill       = fill_count_reg[sel];
    assign base_full  = (CW + INDEX_W)'(sel) * (CW + INDEX_W)'(region_size_reg);
    assign base       = base_full[CW-1:0];
    assign last_stack = ((COUNT_W'(sel) + COUNT_W'(1)) == stack_count_reg);
    assign capacity   = last_stack ? (CW'(TOTAL_SLOTS) - base) : region_size_reg;
    assign top_slot   = base + fill - CW'(1);
    assign wr_addr    = AW'(base + fill);
    assign top_addr   = AW'(top_slot);

    // Status towards the controller
    always_comb
    begin
        dp_stat.command     = item_reg.command;
        dp_stat.bad_index   = (COUNT_W'(sel) >= stack_count_reg);
        dp_stat.full        = (fill >= capacity);
        dp_stat.empty       = (fill == '0);
        dp_stat.remain_zero = (remain_reg == '0);
    end

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load)
        begin
            item_reg <= request;
        end
    end

    // Stack count, region size and fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= COUNT_W'(1);
            region_size_reg <= CW'(TOTAL_SLOTS);
            for (int i = 0; i < MAX_STACKS; i++)
            begin
                fill_count_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            stack_count_reg <= count_clamped;
            region_size_reg <= REGION_TBL[tbl_idx];
            for (int i = 0; i < MAX_STACKS; i++)
            begin
                fill_count_reg[i] <= '0;
            end
        end
        else if (ctrl_cmd.push)
        begin
            fill_count_reg[sel] <= fill + CW'(1);
        end
        else if (ctrl_cmd.read_top && ctrl_cmd.pop)
        begin
            fill_count_reg[sel] <= fill - CW'(1);
        end
    end

    // Walk pointer and words still to come
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.read_top)
        begin
            remain_reg <= ctrl_cmd.pop ? '0 : (fill - CW'(1));
            ptr_reg    <= top_addr - AW'(1);
        end
        else if (ctrl_cmd.read_next)
        begin
            remain_reg <= remain_reg - CW'(1);
            ptr_reg    <= ptr_reg - AW'(1);
        end
    end

    // Slot memory, one write and one registered read
    assign rd_en   = ctrl_cmd.read_top || ctrl_cmd.read_next;
    assign rd_addr = ctrl_cmd.read_top ? top_addr : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.push)
        begin
            mem[wr_addr] <= DATA_WIDTH'(item_reg.data_value);
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result register and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= ctrl_cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.emit)
        begin
            result_reg.status   <= ctrl_cmd.emit_status;
            result_reg.data_out <= ctrl_cmd.emit_data ? WORD_W'(rd_data_reg) : '0;
            result_reg.last     <= ctrl_cmd.emit_last;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== rtl/shared_array_multi_stack.sv =====
// Several stacks in one slot memory. Each item is latched, evaluated, and its result
// registered; push, full, empty and bad index give one result. Pop and list first read
// the newest word through the single registered read port; a list of f words gives f
// results on consecutive cycles. The next item is taken only once busy is low again.
// The fourth command code gives no result, and the receiver cannot stall.
// Asynchronous reset empties all stacks, one stack; memory is not cleared.
module shared_array_multi_stack #(
    parameter int TOTAL_SLOTS = sas_pkg::DEF_TOTAL_SLOTS,
    parameter int DATA_WIDTH  = sas_pkg::DEF_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [sas_pkg::COUNT_W-1:0]  cfg_data,
    input  logic                         start,
    output logic                         busy,
    input  sas_pkg::request_t            request,
    output sas_pkg::result_t             result,
    output logic                         result_valid
);
    import sas_pkg::*;

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_stat;

    // Sequencer
    sas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .dp_stat  (dp_stat),
        .ctrl_cmd (ctrl_cmd)
    );

    // Storage and region maths
    sas_dp #(
        .TOTAL_SLOTS (TOTAL_SLOTS),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .request      (request),
        .ctrl_cmd     (ctrl_cmd),
        .dp_stat      (dp_stat),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef SYNTHESIS
    // A result only follows a cycle of work
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without preceding work");

    // An accepted item starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    // A list streams without gaps until its last word
    a_list_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |=> result_valid)
        else $error("gap inside a list");

    // A store happens only into a valid stack with room
    a_push_legal: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.push |-> (!dp_stat.full && !dp_stat.bad_index))
        else $error("store into a full or invalid stack");
`endif

endmodule
